[hw/rtl/kdlp_pkg.sv]
// Package for the three-key debouncer with long-press detection.
// Holds the phase type, event codes, register indexes and the lane merge struct.
// No dependencies.
`timescale 1ns / 1ps

package kdlp_pkg;

  localparam int unsigned NumKeys = 3;
  localparam int unsigned KeyIdW  = 2;
  localparam int unsigned EventW  = 3;
  localparam int unsigned RegW    = 16;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPress   = 2'd1,
    PhHold    = 2'd2,
    PhRelease = 2'd3
  } phase_e;

  localparam logic [EventW-1:0] EvNone = 3'd0;
  localparam logic [EventW-1:0] EvLong = 3'd4;

  localparam logic [KeyIdW-1:0] KeyOne = 2'd1;

  localparam logic CfgDebounce  = 1'b0;
  localparam logic CfgLongPress = 1'b1;

  localparam logic [RegW-1:0] DebounceReset  = 16'd20;
  localparam logic [RegW-1:0] LongPressReset = 16'd500;

  // What the merge stage found across the key lanes for one tick.
  typedef struct packed {
    logic              any_pressed;
    logic [KeyIdW-1:0] first_key;
    logic              active_pressed;
  } merge_t;

endpackage

[hw/rtl/kdlp_lane.sv]
// One key lane: decodes the active-low pin level of a single key and tells
// whether this key is the one being served. Depends on kdlp_pkg.
`timescale 1ns / 1ps

module kdlp_lane
  import kdlp_pkg::*;
(
  input  logic              level_i,
  input  logic [KeyIdW-1:0] lane_id_i,
  input  logic [KeyIdW-1:0] active_key_i,
  output logic              pressed_o,
  output logic              active_o
);

  assign pressed_o = ~level_i;
  assign active_o  = (lane_id_i == active_key_i);

endmodule

[hw/rtl/kdlp_merge.sv]
// Merge stage: combines the key lanes into the first pressed key in priority
// order and the pressed state of the served key. Depends on kdlp_pkg.
`timescale 1ns / 1ps

module kdlp_merge
  import kdlp_pkg::*;
(
  input  logic [NumKeys-1:0] pressed_i,
  input  logic [NumKeys-1:0] active_i,
  output merge_t             merge_o
);

  logic [KeyIdW-1:0] first_key;

  // Lowest key number wins, so scan from the highest lane down.
  always_comb begin
    first_key = '0;
    for (int k = NumKeys - 1; k >= 0; k--) begin
      if (pressed_i[k]) begin
        first_key = KeyIdW'(k + 1);
      end
    end
  end

  assign merge_o.any_pressed    = |pressed_i;
  assign merge_o.first_key      = first_key;
  assign merge_o.active_pressed = |(pressed_i & active_i);

endmodule

[hw/rtl/key_debounce_long_press.sv]
// Top level of the three-key debouncer with long-press detection on key 1.
// Depends on kdlp_pkg, kdlp_lane and kdlp_merge.
`timescale 1ns / 1ps

// Each input transaction is one 1 ms tick carrying the active-low levels of three
// keys; each tick yields exactly one output transaction in the next cycle, holding
// the key event (0 none, 1..3 short press, 4 long press of key 1) and a busy flag.
// Input and output each move one tick per clock cycle unless the downstream side
// stalls: key decoding runs in three parallel lanes feeding a priority merge, and
// the phase machine with its saturating tick counter advances on each accepted tick.
// The output register frees as soon as the downstream side takes its transaction.
// Both timing registers must be written only while no tick is in flight.

module key_debounce_long_press
  import kdlp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration write port.
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [RegW-1:0] cfg_data_i,
  // Tick input.
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,  // [0] key_one_level, [1] key_two_level,
                                         // [2] key_three_level, [7:3] zero
  // Event output.
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata   // [2:0] key_event, [3] busy_res, [7:4] zero
);

  localparam int unsigned CmpW = (COUNT_BITS > RegW) ? COUNT_BITS : RegW;

  logic [RegW-1:0]       debounce_q;
  logic [RegW-1:0]       long_press_q;
  phase_e                phase_q, phase_d;
  logic [KeyIdW-1:0]     key_q, key_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  long_q, long_d;
  logic                  m_valid_q;
  logic [EventW-1:0]     event_q;
  logic                  busy_q;
  logic [EventW-1:0]     event_d;

  logic [NumKeys-1:0]    lane_pressed;
  logic [NumKeys-1:0]    lane_active;
  merge_t                merge;
  logic                  s_fire;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  cnt_sat;
  logic                  deb_hit;
  logic                  long_hit;
  logic                  key_one;
  logic                  drop_press;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    kdlp_lane u_lane (
      .level_i      (s_axis_tdata[k]),
      .lane_id_i    (KeyIdW'(k + 1)),
      .active_key_i (key_q),
      .pressed_o    (lane_pressed[k]),
      .active_o     (lane_active[k])
    );
  end

  kdlp_merge u_merge (
    .pressed_i (lane_pressed),
    .active_i  (lane_active),
    .merge_o   (merge)
  );

  // Saturating increment; a saturated counter meets every threshold.
  assign cnt_sat    = &cnt_q;
  assign cnt_inc    = cnt_sat ? cnt_q : cnt_q + 1'b1;
  assign deb_hit    = (CmpW'(cnt_inc) >= CmpW'(debounce_q)) || (&cnt_inc);
  assign long_hit   = (CmpW'(cnt_inc) >= CmpW'(long_press_q)) || (&cnt_inc);
  assign key_one    = (key_q == KeyOne);
  assign drop_press = key_one & ~merge.active_pressed;

  // Next phase.
  always_comb begin
    case (phase_q)
      PhIdle:    phase_d = merge.any_pressed ? PhPress : PhIdle;
      PhPress: begin
        if (deb_hit) begin
          phase_d = drop_press ? PhIdle : PhHold;
        end else begin
          phase_d = PhPress;
        end
      end
      PhHold:    phase_d = merge.active_pressed ? PhHold : PhRelease;
      PhRelease: phase_d = deb_hit ? PhIdle : PhRelease;
      default:   phase_d = PhIdle;
    endcase
  end

  // Counter, served key, long mark and event.
  always_comb begin
    cnt_d   = cnt_q;
    key_d   = key_q;
    long_d  = long_q;
    event_d = EvNone;
    case (phase_q)
      PhIdle: begin
        if (merge.any_pressed) begin
          key_d = merge.first_key;
          cnt_d = '0;
        end
      end
      PhPress: begin
        cnt_d = cnt_inc;
        if (deb_hit && !drop_press) begin
          cnt_d  = '0;
          long_d = 1'b0;
        end
      end
      PhHold: begin
        if (merge.active_pressed) begin
          cnt_d = cnt_inc;
          if (key_one && long_hit) begin
            long_d = 1'b1;
          end
        end else begin
          cnt_d = '0;
        end
      end
      PhRelease: begin
        cnt_d = cnt_inc;
        if (deb_hit) begin
          event_d = (key_one && long_q) ? EvLong : EventW'(key_q);
          long_d  = 1'b0;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounce:  debounce_q   <= cfg_data_i;
        CfgLongPress: long_press_q <= cfg_data_i;
        default:      debounce_q   <= debounce_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      key_q   <= '0;
      cnt_q   <= '0;
      long_q  <= 1'b0;
    end else if (s_fire) begin
      phase_q <= phase_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
      long_q  <= long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      event_q <= event_d;
      busy_q  <= (phase_d != PhIdle);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, busy_q, event_q};

endmodule

[dv/key_debounce_long_press_tb.sv]
// Self-checking testbench for key_debounce_long_press.
// Drives 1 ms key ticks against a built-in model of the debounce and long-press logic.
// Depends on kdlp_pkg and the key_debounce_long_press RTL.
`timescale 1ns / 1ps

module key_debounce_long_press_tb;
  import kdlp_pkg::*;

  localparam int unsigned CountW     = 16;
  localparam int          StuckLimit = 200;

  typedef struct {
    logic [EventW-1:0] key_event;
    logic              busy;
  } key_report_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [RegW-1:0] cfg_data_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata;   // [0] key_one_level, [1] key_two_level,
                                   // [2] key_three_level, [7:3] zero
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;   // [2:0] key_event, [3] busy_res, [7:4] zero

  // Model state and timing registers.
  phase_e            ph        = PhIdle;
  logic [KeyIdW-1:0] cur_key   = '0;
  logic [CountW-1:0] cnt       = '0;
  logic              long_flag = 1'b0;
  logic [RegW-1:0]   dbnc_cfg  = DebounceReset;
  logic [RegW-1:0]   long_cfg  = LongPressReset;

  key_report_t report_q[$];
  int          mismatch_count = 0;
  int          ticks_sent     = 0;
  int          stall_left     = 0;
  int          stuck          = 0;
  bit          idling         = 1'b1;

  key_debounce_long_press #(
    .COUNT_BITS(CountW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit key_down(input logic [2:0] lv, input logic [KeyIdW-1:0] k);
    if (k == '0) return 1'b0;
    return !lv[k-1];
  endfunction

  function automatic void bump_count();
    if (cnt != '1) cnt++;
  endfunction

  // A saturated counter has reached every threshold.
  function automatic bit count_hit(input logic [RegW-1:0] limit);
    return (cnt >= limit) || (cnt == '1);
  endfunction

  // Advances the model by one tick and queues the report the block must produce.
  function automatic void advance_key_fsm(input logic [2:0] lv);
    logic [EventW-1:0] ev;
    ev = EvNone;
    case (ph)
      PhIdle: begin
        for (int k = 1; k <= NumKeys; k++) begin
          if (ph == PhIdle && key_down(lv, KeyIdW'(k))) begin
            cur_key = KeyIdW'(k);
            cnt     = '0;
            ph      = PhPress;
          end
        end
      end
      PhPress: begin
        bump_count();
        if (count_hit(dbnc_cfg)) begin
          if (cur_key == KeyOne && !key_down(lv, KeyOne)) begin
            ph = PhIdle;
          end else begin
            ph        = PhHold;
            cnt       = '0;
            long_flag = 1'b0;
          end
        end
      end
      PhHold: begin
        if (key_down(lv, cur_key)) begin
          bump_count();
          if (cur_key == KeyOne && count_hit(long_cfg)) long_flag = 1'b1;
        end else begin
          cnt = '0;
          ph  = PhRelease;
        end
      end
      default: begin
        bump_count();
        if (count_hit(dbnc_cfg)) begin
          ev        = (cur_key == KeyOne && long_flag) ? EvLong : {1'b0, cur_key};
          long_flag = 1'b0;
          ph        = PhIdle;
        end
      end
    endcase
    report_q.push_back('{key_event: ev, busy: (ph != PhIdle)});
  endfunction

  task automatic send_tick(input logic [2:0] lv);
    if (idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lv};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_key_fsm(lv);
    ticks_sent++;
  endtask

  // Stops the tick stream and waits until every queued report has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (report_q.size() != 0);
  endtask

  task automatic set_timing(input logic [RegW-1:0] dbnc, input logic [RegW-1:0] longp);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgDebounce;
    cfg_data_i <= dbnc;
    @(posedge clk_i);
    cfg_idx_i  <= CfgLongPress;
    cfg_data_i <= longp;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dbnc_cfg = dbnc;
    long_cfg = longp;
  endtask

  function automatic logic [2:0] stray_levels(input bit mixed);
    logic [2:0] lv;
    lv = 3'b111;
    if (mixed) begin
      for (int b = 0; b < 3; b++) begin
        if ($urandom_range(0, 7) == 0) lv[b] = 1'b0;
      end
    end
    return lv;
  endfunction

  // Holds one key for the given ticks, then releases it long enough to finish.
  task automatic press_key(input int key, input int held, input bit mixed);
    logic [2:0] lv;
    repeat (held) begin
      lv = stray_levels(mixed);
      lv[key-1] = 1'b0;
      send_tick(lv);
    end
    repeat (int'(dbnc_cfg) + 2) begin
      lv = stray_levels(mixed);
      lv[key-1] = 1'b1;
      send_tick(lv);
    end
  endtask

  task automatic test_reset_config();
    press_key(3, 25, 1'b0);
    press_key(1, 530, 1'b0);
  endtask

  task automatic test_directed();
    set_timing(16'd1, 16'd3);
    // All keys down at once: key 1 wins, then keys 2 and 3 down: key 2 wins.
    repeat (3) send_tick(3'b000);
    repeat (3) send_tick(3'b111);
    repeat (3) send_tick(3'b001);
    repeat (3) send_tick(3'b111);
    press_key(3, 3, 1'b0);
    // A long press must not leave a mark that hides the following short one.
    press_key(1, 6, 1'b0);
    press_key(1, 3, 1'b0);
    // Key 1 released inside the press debounce is dropped; key 2 is kept.
    press_key(1, 1, 1'b0);
    press_key(2, 1, 1'b0);
  endtask

  task automatic test_zero_settings();
    set_timing(16'd0, 16'd0);
    press_key(1, 2, 1'b0);
    press_key(1, 3, 1'b0);
    press_key(1, 1, 1'b0);
    press_key(2, 2, 1'b0);
  endtask

  // Full-scale long-press threshold stays short; a longer debounce on key 2.
  task automatic test_wide_thresholds();
    set_timing(16'd1, 16'hFFFF);
    press_key(1, 300, 1'b0);
    set_timing(16'd40, 16'd1);
    press_key(2, 1, 1'b0);
  endtask

  task automatic test_random();
    int phase_no;
    int goal;
    int pick;
    int key;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      set_timing(RegW'($urandom_range(0, 6)), RegW'($urandom_range(0, 30)));
      idling = (phase_no != 3);
      goal = ticks_sent + 175;
      while (ticks_sent < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          key = $urandom_range(1, 3);
          press_key(key, $urandom_range(1, int'(dbnc_cfg) + 2 * int'(long_cfg) + 4), 1'b1);
        end else if (pick < 19) begin
          repeat ($urandom_range(1, 6)) send_tick(3'($urandom_range(0, 7)));
        end else begin
          drain_results();
        end
      end
    end
  endtask

  // Downstream side: random stall bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    key_report_t exp_rep;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual tdata %h",
                 $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_rep = report_q.pop_front();
        if (m_axis_tdata[2:0] !== exp_rep.key_event) begin
          $display("%0t: key_event expected %0d actual %0d",
                   $time, exp_rep.key_event, m_axis_tdata[2:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[3] !== exp_rep.busy) begin
          $display("%0t: busy_res expected %0d actual %0d",
                   $time, exp_rep.busy, m_axis_tdata[3]);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck == StuckLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgDebounce;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h07;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_directed();
    test_zero_settings();
    test_wide_thresholds();
    test_random();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/kdlp_pkg.sv
hw/rtl/kdlp_lane.sv
hw/rtl/kdlp_merge.sv
hw/rtl/key_debounce_long_press.sv
dv/key_debounce_long_press_tb.sv
